// File: design/ffha_pkg.sv
package ffha_pkg;

  // Default sizing of the heap and of the block table.
  localparam int unsigned DEF_HEAP_BYTES   = 1024;
  localparam int unsigned DEF_HEADER_BYTES = 24;
  localparam int unsigned DEF_ARRAY_LIMIT  = 1000;
  localparam int unsigned DEF_MAX_BLOCKS   = 64;

  // Fixed widths of the request and result fields.
  localparam int unsigned OPC_W  = 2;
  localparam int unsigned ADDR_W = 10;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned STAT_W = 2;

  typedef enum logic [OPC_W-1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_ARRAY  = 2'd2,
    OP_RESIZE = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_NOMEM   = 2'd1,
    ST_NOBLOCK = 2'd2
  } status_t;

  // Command broadcast along the row of cells.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_INS,
    CELL_REM,
    CELL_WR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     w0_en;
    logic     w0_free;
    logic     w1_en;
    logic     w1_free;
  } cell_ctl_t;

endpackage

// File: design/ffha_cell.sv
// One entry of the block table. The row rotates left to bring each entry
// to the window at cell zero, and opens or closes a slot behind the window.
module ffha_cell #(
  parameter int unsigned AW        = 11,
  parameter int unsigned LW        = 7,
  parameter int unsigned IDX       = 0,
  parameter int unsigned RST_BYTES = 0,
  parameter bit          RST_FREE  = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ffha_pkg::cell_ctl_t ctl,
  input  logic [LW-1:0]       lim,
  input  logic [AW-1:0]       w0_bytes,
  input  logic [AW-1:0]       w1_bytes,
  input  logic [AW-1:0]       left_bytes,
  input  logic                left_free,
  input  logic [AW-1:0]       right_bytes,
  input  logic                right_free,
  output logic [AW-1:0]       bytes_o,
  output logic                free_o
);

  localparam logic [LW-1:0] MY_IDX = LW'(IDX);

  logic [AW-1:0] bytes_r, bytes_nxt;
  logic          free_r, free_nxt;

  always_comb begin
    bytes_nxt = bytes_r;
    free_nxt  = free_r;
    case (ctl.op)
      ffha_pkg::CELL_ROT: begin
        bytes_nxt = right_bytes;
        free_nxt  = right_free;
      end
      ffha_pkg::CELL_INS: begin
        if (IDX == 0) begin
          if (ctl.w0_en) begin
            bytes_nxt = w0_bytes;
            free_nxt  = ctl.w0_free;
          end
        end else if (IDX == 1) begin
          bytes_nxt = w1_bytes;
          free_nxt  = ctl.w1_free;
        end else if (MY_IDX <= lim) begin
          bytes_nxt = left_bytes;
          free_nxt  = left_free;
        end
      end
      ffha_pkg::CELL_REM: begin
        if (IDX == 0) begin
          if (ctl.w0_en) begin
            bytes_nxt = w0_bytes;
            free_nxt  = ctl.w0_free;
          end
        end else if (MY_IDX == lim) begin
          bytes_nxt = '0;
          free_nxt  = 1'b0;
        end else if (MY_IDX < lim) begin
          bytes_nxt = right_bytes;
          free_nxt  = right_free;
        end
      end
      ffha_pkg::CELL_WR: begin
        if (IDX == 0 && ctl.w0_en) begin
          bytes_nxt = w0_bytes;
          free_nxt  = ctl.w0_free;
        end else if (IDX == 1 && ctl.w1_en) begin
          bytes_nxt = w1_bytes;
          free_nxt  = ctl.w1_free;
        end
      end
      default: begin
        bytes_nxt = bytes_r;
        free_nxt  = free_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_r <= AW'(RST_BYTES);
      free_r  <= RST_FREE;
    end else begin
      bytes_r <= bytes_nxt;
      free_r  <= free_nxt;
    end
  end

  assign bytes_o = bytes_r;
  assign free_o  = free_r;

endmodule

// File: design/ffha_ctrl.sv
// Request sequencer. Each pass rotates the row once round, looking at the
// window (cell zero) and its neighbour (cell one).
module ffha_ctrl #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int unsigned ARRAY_LIMIT  = ffha_pkg::DEF_ARRAY_LIMIT,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned AW           = 11,
  parameter int unsigned LW           = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffha_pkg::OPC_W-1:0]    in_opcode,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_address,
  input  logic [ffha_pkg::LEN_W-1:0]    in_length,
  input  logic [ffha_pkg::LEN_W-1:0]    in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::STAT_W-1:0]   out_status,
  output logic [ffha_pkg::ADDR_W-1:0]   out_result_address,
  output logic                          out_moved,
  output logic [ffha_pkg::ADDR_W-1:0]   out_copy_length,
  output logic [ffha_pkg::ADDR_W-1:0]   out_zero_length,
  input  logic [AW-1:0]                 c0_bytes,
  input  logic                          c0_free,
  input  logic [AW-1:0]                 c1_bytes,
  input  logic                          c1_free,
  output ffha_pkg::cell_ctl_t           ctl,
  output logic [AW-1:0]                 w0_bytes,
  output logic [AW-1:0]                 w1_bytes,
  output logic [LW-1:0]                 lim
);

  localparam int unsigned LEN_W = ffha_pkg::LEN_W;
  localparam int unsigned CW    = (AW > LEN_W ? AW : LEN_W) + 2;
  localparam logic [CW-1:0] HC  = CW'(HEADER_BYTES);
  localparam logic [AW-1:0] HA  = AW'(HEADER_BYTES);

  typedef enum logic [1:0] {S_IDLE, S_DISP, S_PASS, S_FIN} state_t;
  typedef enum logic [1:0] {K_ALLOC, K_REL, K_RSZ} kind_t;

  state_t                        state_r;
  kind_t                         kind_r;
  ffha_pkg::opcode_t             op_r;
  ffha_pkg::status_t             st_r;
  logic [ffha_pkg::ADDR_W-1:0]   addr_r;
  logic [LEN_W-1:0]              len_r;
  logic [LEN_W-1:0]              zero_r;
  logic [2*LEN_W-1:0]            prod_r;
  logic                          mv_r, done_r;
  logic [AW-1:0]                 old_r, res_r, off_r;
  logic [LW-1:0]                 rot_r, count_r;
  logic                          out_valid_r, out_moved_r;
  logic [ffha_pkg::STAT_W-1:0]   out_status_r;
  logic [ffha_pkg::ADDR_W-1:0]   out_res_r, out_copy_r, out_zero_r;

  // Window view.
  logic          v0, v1, room, on_addr0, on_addr1;
  logic [CW-1:0] b0c, b1c, lenc, totc;
  logic [AW-1:0] off1;

  // Step decision.
  logic              act, rotate, last, act_hit, act_mv, cnt_inc, cnt_dec;
  ffha_pkg::status_t act_st;
  logic [AW-1:0]     act_res;

  assign v0       = rot_r < count_r;
  assign v1       = ({1'b0, rot_r} + 1'b1) < {1'b0, count_r};
  assign room     = count_r < LW'(MAX_BLOCKS);
  assign b0c      = CW'(c0_bytes);
  assign b1c      = CW'(c1_bytes);
  assign lenc     = CW'(len_r);
  assign totc     = b0c + b1c + HC;
  assign off1     = off_r + HA + c0_bytes;
  assign on_addr0 = CW'(off_r) == CW'(addr_r);
  assign on_addr1 = CW'(off1) == CW'(addr_r);

  always_comb begin
    ctl      = '{op: ffha_pkg::CELL_HOLD, w0_en: 1'b0, w0_free: 1'b0,
                 w1_en: 1'b0, w1_free: 1'b0};
    w0_bytes = '0;
    w1_bytes = '0;
    lim      = '0;
    act      = 1'b0;
    act_hit  = 1'b0;
    act_mv   = 1'b0;
    act_st   = ffha_pkg::ST_OK;
    act_res  = '0;
    cnt_inc  = 1'b0;
    cnt_dec  = 1'b0;
    rotate   = 1'b0;
    if (state_r == S_PASS) begin
      if (!done_r) begin
        case (kind_r)
          K_ALLOC: begin
            if (v0 && c0_free) begin
              if (len_r == '0) begin
                if (b0c > HC + 1'b1) begin
                  act         = 1'b1;
                  act_hit     = 1'b1;
                  act_res     = off_r;
                  cnt_inc     = 1'b1;
                  ctl.op      = ffha_pkg::CELL_INS;
                  ctl.w0_en   = 1'b1;
                  ctl.w1_free = 1'b1;
                  w1_bytes    = AW'(b0c - HC);
                  lim         = count_r - rot_r;
                end
              end else if (b0c >= lenc) begin
                act       = 1'b1;
                act_hit   = 1'b1;
                act_res   = off_r;
                ctl.w0_en = 1'b1;
                if (room && b0c >= lenc + HC + 1'b1) begin
                  cnt_inc     = 1'b1;
                  ctl.op      = ffha_pkg::CELL_INS;
                  ctl.w1_free = 1'b1;
                  w0_bytes    = AW'(len_r);
                  w1_bytes    = AW'(b0c - lenc - HC);
                  lim         = count_r - rot_r;
                end else begin
                  ctl.op   = ffha_pkg::CELL_WR;
                  w0_bytes = c0_bytes;
                end
              end
            end
          end
          K_REL: begin
            // The target is marked one step ahead so that it can still merge
            // with the block in the window.
            if (v0 && on_addr0) begin
              act = 1'b1;
              if (c0_free) begin
                act_st = ffha_pkg::ST_NOBLOCK;
              end else begin
                ctl.op      = ffha_pkg::CELL_WR;
                ctl.w0_en   = 1'b1;
                ctl.w0_free = 1'b1;
                w0_bytes    = c0_bytes;
              end
            end else if (v1 && on_addr1) begin
              act = 1'b1;
              if (c1_free) begin
                act_st = ffha_pkg::ST_NOBLOCK;
              end else begin
                ctl.op      = ffha_pkg::CELL_WR;
                ctl.w1_en   = 1'b1;
                ctl.w1_free = 1'b1;
                w1_bytes    = c1_bytes;
              end
            end
          end
          K_RSZ: begin
            if (v0 && on_addr0) begin
              act = 1'b1;
              if (c0_free) begin
                act_st = ffha_pkg::ST_NOBLOCK;
              end else if (lenc <= b0c) begin
                act_res = AW'(addr_r);
                if (room && (b0c - lenc) >= HC + 1'b1) begin
                  cnt_inc     = 1'b1;
                  ctl.op      = ffha_pkg::CELL_INS;
                  ctl.w0_en   = 1'b1;
                  ctl.w1_free = 1'b1;
                  w0_bytes    = AW'(len_r);
                  w1_bytes    = AW'(b0c - lenc - HC);
                  lim         = count_r - rot_r;
                end
              end else if (v1 && c1_free && totc >= lenc) begin
                act_res   = AW'(addr_r);
                ctl.w0_en = 1'b1;
                if (totc >= lenc + HC + 1'b1) begin
                  ctl.op      = ffha_pkg::CELL_WR;
                  ctl.w1_en   = 1'b1;
                  ctl.w1_free = 1'b1;
                  w0_bytes    = AW'(len_r);
                  w1_bytes    = AW'(totc - lenc - HC);
                end else begin
                  cnt_dec  = 1'b1;
                  ctl.op   = ffha_pkg::CELL_REM;
                  w0_bytes = AW'(totc);
                  lim      = count_r - rot_r - 1'b1;
                end
              end else begin
                act_mv = 1'b1;
              end
            end
          end
          default: act = 1'b0;
        endcase
      end
      if (!act) begin
        if (v1 && c0_free && c1_free) begin
          cnt_dec     = 1'b1;
          ctl.op      = ffha_pkg::CELL_REM;
          ctl.w0_en   = 1'b1;
          ctl.w0_free = 1'b1;
          w0_bytes    = AW'(totc);
          lim         = count_r - rot_r - 1'b1;
        end else begin
          rotate = 1'b1;
          ctl.op = ffha_pkg::CELL_ROT;
        end
      end
    end
  end

  assign last = rotate && (rot_r == LW'(MAX_BLOCKS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      count_r     <= LW'(1);
      rot_r       <= '0;
      done_r      <= 1'b0;
      mv_r        <= 1'b0;
      kind_r      <= K_ALLOC;
      st_r        <= ffha_pkg::ST_OK;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r    <= ffha_pkg::opcode_t'(in_opcode);
            addr_r  <= in_address;
            len_r   <= in_length;
            prod_r  <= in_length * in_count;
            state_r <= S_DISP;
          end
        end
        S_DISP: begin
          st_r   <= ffha_pkg::ST_OK;
          res_r  <= '0;
          mv_r   <= 1'b0;
          zero_r <= '0;
          rot_r  <= '0;
          off_r  <= HA;
          done_r <= 1'b0;
          unique case (op_r)
            ffha_pkg::OP_FREE: begin
              kind_r  <= K_REL;
              state_r <= (addr_r == '0) ? S_FIN : S_PASS;
            end
            ffha_pkg::OP_ARRAY: begin
              kind_r <= K_ALLOC;
              if (prod_r == '0) begin
                len_r <= '0;
                if (room) begin
                  state_r <= S_PASS;
                end else begin
                  st_r    <= ffha_pkg::ST_NOMEM;
                  state_r <= S_FIN;
                end
              end else if (prod_r > (2*LEN_W)'(ARRAY_LIMIT)) begin
                st_r    <= ffha_pkg::ST_NOMEM;
                state_r <= S_FIN;
              end else begin
                len_r   <= prod_r[LEN_W-1:0];
                zero_r  <= prod_r[LEN_W-1:0];
                state_r <= S_PASS;
              end
            end
            ffha_pkg::OP_RESIZE: begin
              if (addr_r == '0) begin
                kind_r <= K_ALLOC;
                if (len_r == '0 && !room) begin
                  st_r    <= ffha_pkg::ST_NOMEM;
                  state_r <= S_FIN;
                end else begin
                  state_r <= S_PASS;
                end
              end else begin
                kind_r  <= (len_r == '0) ? K_REL : K_RSZ;
                state_r <= S_PASS;
              end
            end
            default: begin
              kind_r <= K_ALLOC;
              if (len_r == '0 && !room) begin
                st_r    <= ffha_pkg::ST_NOMEM;
                state_r <= S_FIN;
              end else begin
                state_r <= S_PASS;
              end
            end
          endcase
        end
        S_PASS: begin
          if (act) begin
            done_r <= 1'b1;
            if (act_st != ffha_pkg::ST_OK) begin
              st_r <= act_st;
            end
            if (act_hit || (kind_r == K_RSZ && !act_mv && !c0_free)) begin
              res_r <= act_res;
            end
            if (act_mv) begin
              mv_r  <= 1'b1;
              old_r <= c0_bytes;
            end
          end
          if (cnt_inc) begin
            count_r <= count_r + 1'b1;
          end else if (cnt_dec) begin
            count_r <= count_r - 1'b1;
          end
          if (rotate && !last) begin
            rot_r <= rot_r + 1'b1;
            if (v0) begin
              off_r <= off1;
            end
          end
          if (last) begin
            rot_r  <= '0;
            off_r  <= HA;
            done_r <= 1'b0;
            case (kind_r)
              K_ALLOC: begin
                if (done_r && mv_r) begin
                  kind_r <= K_REL;
                end else begin
                  state_r <= S_FIN;
                  if (!done_r) begin
                    st_r  <= ffha_pkg::ST_NOMEM;
                    res_r <= '0;
                    mv_r  <= 1'b0;
                  end
                end
              end
              K_RSZ: begin
                if (mv_r) begin
                  kind_r <= K_ALLOC;
                end else begin
                  state_r <= S_FIN;
                  if (!done_r) begin
                    st_r <= ffha_pkg::ST_NOBLOCK;
                  end
                end
              end
              default: begin
                state_r <= S_FIN;
                if (!done_r) begin
                  st_r <= ffha_pkg::ST_NOBLOCK;
                end
              end
            endcase
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= st_r;
            out_res_r    <= (st_r == ffha_pkg::ST_OK) ? res_r[ffha_pkg::ADDR_W-1:0] : '0;
            out_moved_r  <= mv_r && (st_r == ffha_pkg::ST_OK);
            out_copy_r   <= (mv_r && st_r == ffha_pkg::ST_OK) ?
                            old_r[ffha_pkg::ADDR_W-1:0] : '0;
            out_zero_r   <= (op_r == ffha_pkg::OP_ARRAY && st_r == ffha_pkg::ST_OK) ?
                            zero_r[ffha_pkg::ADDR_W-1:0] : '0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = state_r != S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_result_address = out_res_r;
  assign out_moved          = out_moved_r;
  assign out_copy_length    = out_copy_r;
  assign out_zero_length    = out_zero_r;

endmodule

// File: design/first_fit_heap_allocator_unit.sv
// Channel  | Direction | Handshake          | Payload
// request  | in        | in_valid/in_stall  | in_opcode, in_address, in_length, in_count
// result   | out       | out_valid/out_stall| out_status, out_result_address, out_moved,
//          |           |                    | out_copy_length, out_zero_length
//
// A request is decoded and then makes one pass of MAX_BLOCKS rotations of
// the cell row, and the row holds its rotation for each split, merge or
// update made on the way. A resize that has to move takes three passes; a
// free of null or a request refused at dispatch makes no pass. The passes
// come from the rotating row of table cells. Reset is synchronous and
// active low; it leaves one free block of HEAP_BYTES - HEADER_BYTES bytes.
// A new request is taken while a finished result is still held in the
// output register waiting for its transfer.
//
// The block table lives in a row of cells. In each pass the row rotates
// once round, so that every entry visits the window at cell zero in address
// order; the sequencer keeps the running data offset of the window. Behind
// the window the cells can open a slot (split) or close one (merge or
// absorb), each cell deciding from its own index against the broadcast
// limit. Adjacent free blocks are merged whenever the window sees them.
module first_fit_heap_allocator_unit #(
  parameter int unsigned HEAP_BYTES   = ffha_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffha_pkg::DEF_HEADER_BYTES,
  parameter int unsigned ARRAY_LIMIT  = ffha_pkg::DEF_ARRAY_LIMIT,
  parameter int unsigned MAX_BLOCKS   = ffha_pkg::DEF_MAX_BLOCKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffha_pkg::OPC_W-1:0]    in_opcode,
  input  logic [ffha_pkg::ADDR_W-1:0]   in_address,
  input  logic [ffha_pkg::LEN_W-1:0]    in_length,
  input  logic [ffha_pkg::LEN_W-1:0]    in_count,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffha_pkg::STAT_W-1:0]   out_status,
  output logic [ffha_pkg::ADDR_W-1:0]   out_result_address,
  output logic                          out_moved,
  output logic [ffha_pkg::ADDR_W-1:0]   out_copy_length,
  output logic [ffha_pkg::ADDR_W-1:0]   out_zero_length
);

  // Offsets and block sizes share one width, wide enough for the offset
  // just past the last block.
  localparam int unsigned AW = $clog2(HEAP_BYTES + HEADER_BYTES + 1);
  localparam int unsigned LW = $clog2(MAX_BLOCKS + 1);

  ffha_pkg::cell_ctl_t ctl;
  logic [AW-1:0]       w0_bytes, w1_bytes;
  logic [LW-1:0]       lim;
  logic [AW-1:0]       cell_bytes [MAX_BLOCKS];
  logic                cell_free  [MAX_BLOCKS];

  for (genvar j = 0; j < MAX_BLOCKS; j++) begin : g_cell
    ffha_cell #(
      .AW        (AW),
      .LW        (LW),
      .IDX       (j),
      .RST_BYTES ((j == 0) ? HEAP_BYTES - HEADER_BYTES : 0),
      .RST_FREE  (j == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .lim         (lim),
      .w0_bytes    (w0_bytes),
      .w1_bytes    (w1_bytes),
      .left_bytes  (cell_bytes[(j + MAX_BLOCKS - 1) % MAX_BLOCKS]),
      .left_free   (cell_free[(j + MAX_BLOCKS - 1) % MAX_BLOCKS]),
      .right_bytes (cell_bytes[(j + 1) % MAX_BLOCKS]),
      .right_free  (cell_free[(j + 1) % MAX_BLOCKS]),
      .bytes_o     (cell_bytes[j]),
      .free_o      (cell_free[j])
    );
  end

  ffha_ctrl #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .ARRAY_LIMIT  (ARRAY_LIMIT),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .AW           (AW),
    .LW           (LW)
  ) u_ctrl (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_address         (in_address),
    .in_length          (in_length),
    .in_count           (in_count),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_address (out_result_address),
    .out_moved          (out_moved),
    .out_copy_length    (out_copy_length),
    .out_zero_length    (out_zero_length),
    .c0_bytes           (cell_bytes[0]),
    .c0_free            (cell_free[0]),
    .c1_bytes           (cell_bytes[1]),
    .c1_free            (cell_free[1]),
    .ctl                (ctl),
    .w0_bytes           (w0_bytes),
    .w1_bytes           (w1_bytes),
    .lim                (lim)
  );

endmodule

// File: design/ffha_checker.sv
module ffha_props (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [ffha_pkg::STAT_W-1:0]   out_status,
  input logic [ffha_pkg::ADDR_W-1:0]   out_result_address,
  input logic                          out_moved,
  input logic [ffha_pkg::ADDR_W-1:0]   out_copy_length,
  input logic [ffha_pkg::ADDR_W-1:0]   out_zero_length
);

  // A held result keeps its status, result address and copy length.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_result_address) && $stable(out_copy_length))
    else $error("result changed while stalled");

  // One request at a time: the request side is busy straight after a transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while one is in work");

  // A failed request gives a null address and no move.
  a_fail_null: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ffha_pkg::ST_OK |->
    out_result_address == '0 && !out_moved && out_copy_length == '0)
    else $error("failed request reports an allocation");

  // A zero-fill length only comes with a successful array allocation.
  a_zero_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length != '0 |->
    out_status == ffha_pkg::ST_OK && !out_moved && out_result_address != '0)
    else $error("zero-fill length on a result that is not an allocation");

endmodule

bind first_fit_heap_allocator_unit ffha_props u_ffha_props (.*);
